// ===== hw/rtl/plpe_pkg.sv =====
package plpe_pkg;

    localparam int unsigned VEL_W   = 16;
    localparam int unsigned RATE_W  = 24;
    localparam int unsigned TS_W    = 16;
    localparam int unsigned POS_W   = 48;
    localparam int unsigned HDG_W   = 32;
    localparam int unsigned TRIG_W  = 16;
    localparam int unsigned TAB_W   = 15;
    localparam int unsigned SER_W   = 16;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned WIDE_W  = 32;
    localparam int unsigned DX_W    = 33;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;

    localparam logic [TS_W-1:0] TIME_STEP_RESET = 16'd655;
    localparam logic            REG_TIME_STEP   = 1'b0;

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam logic [63:0] TAYLOR_DIV [14] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
    };

    typedef struct packed {
        logic signed [VEL_W-1:0]  vel_x;
        logic signed [VEL_W-1:0]  vel_y;
        logic signed [RATE_W-1:0] turn_rate;
    } t_in_word;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [HDG_W-1:0]        heading;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_SIN,
        ST_RD_COS,
        ST_LD_COS,
        ST_VEL,
        ST_MID,
        ST_STEP,
        ST_ROUND,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic clr;
        logic en;
    } t_lane_ctl;

    // (a * b) >> 62, truncated to 64 bits
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // quarter-wave entry round(32767*sin), evaluated at elaboration
    function automatic logic [TAB_W-1:0] quarter_sine(input logic [15:0] k,
                                                      input logic [4:0] angle_bits);
        logic [63:0] frac;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        frac = {48'd0, k} << (7'd64 - {2'd0, angle_bits});
        x    = mul_q62(HALF_PI_Q62, frac);
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (int n = 0; n < 14; n++) begin
            term = mul_q62(term, x2) / TAYLOR_DIV[n];
            if (n % 2 == 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = ((sum >> 17) * 64'd32767 + (64'd1 << 44)) >> 45;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[TAB_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/plpe_lane.sv =====
module plpe_lane #(
    parameter int unsigned DW = 32
) (
    input  logic                                    i_clk,
    input  plpe_pkg::t_lane_ctl                     i_ctl,
    input  logic signed [DW-1:0]                    i_addend,
    output logic signed [DW+plpe_pkg::SER_W-1:0]    o_prod
);

    logic signed [DW-1:0]              r_hi;
    logic [plpe_pkg::SER_W-1:0]        r_lo;
    logic signed [DW:0]                n_sum;

    // one multiplier bit per enabled cycle, lsb first, partial product shifts right
    always_comb begin
        n_sum = {i_addend[DW-1], i_addend} + {r_hi[DW-1], r_hi};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_hi <= '0;
            r_lo <= '0;
        end else if (i_ctl.en) begin
            r_hi <= n_sum[DW:1];
            r_lo <= {n_sum[0], r_lo[plpe_pkg::SER_W-1:1]};
        end
    end

    assign o_prod = {r_hi, r_lo};

endmodule

// ===== hw/rtl/planar_pose_euler_integrator.sv =====
// Planar pose integrator: dead-reckoning odometry by forward Euler steps.
// Input channel (i_in_valid / o_in_ready, i_in_word): one body-frame velocity
// word, forward and lateral speed in mm/s and turn rate in 2^-16 turn/s.
// Output channel (o_out_valid / i_out_ready, o_out_word): the new pose, x and
// y in 2^-16 mm (saturating) and a 32-bit binary heading, one word per input.
// The APB port holds time_step (Q0.16 s) at byte address 0; write it only
// while no word is in flight.
// The pose word is registered when the last step (UPDATE) finds the output
// register free; only then does the block return to idle and take the next
// input word. The work is two bit-serial passes: one over the velocity bits in
// the x and y lanes for the rotation, one over the time-step bits in those lanes
// and the heading lane for the scaling of position and heading.
// Sine and cosine come from a quarter-wave table read one entry per cycle.
// Reset clears the pose to zero, sets time_step to 655 and empties the output
// register. The output register holds a finished word while the receiver
// stalls; a new word is accepted meanwhile, and its pose update waits in its
// last step until the register is free.
module planar_pose_euler_integrator #(
    parameter int unsigned ANGLE_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  plpe_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output plpe_pkg::t_out_word               o_out_word,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [plpe_pkg::ADDR_W-1:0]       paddr,
    input  logic [plpe_pkg::DATA_W-1:0]       pwdata,
    output logic [plpe_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int unsigned QUARTER_LEN = 1 << (ANGLE_BITS - 2);
    localparam int unsigned ROM_AW      = ANGLE_BITS - 1;
    localparam logic [ROM_AW-1:0]     QUARTER_ADDR = ROM_AW'(QUARTER_LEN);
    localparam logic [ANGLE_BITS-1:0] QUARTER_IDX  = ANGLE_BITS'(QUARTER_LEN);
    localparam logic [plpe_pkg::CNT_W-1:0] CNT_LAST =
        plpe_pkg::CNT_W'(plpe_pkg::SER_W - 1);
    localparam logic signed [plpe_pkg::POS_W-1:0] POS_MAX = {1'b0, {(plpe_pkg::POS_W-1){1'b1}}};
    localparam logic signed [plpe_pkg::POS_W-1:0] POS_MIN = {1'b1, {(plpe_pkg::POS_W-1){1'b0}}};
    localparam logic signed [plpe_pkg::POS_W-1:0] RND_POS = 48'sd16384;
    localparam logic signed [plpe_pkg::POS_W-1:0] RND_NEG = 48'sd16383;

    function automatic logic signed [plpe_pkg::POS_W-1:0] sat_add(
        input logic signed [plpe_pkg::POS_W-1:0] a,
        input logic signed [plpe_pkg::DX_W-1:0]  d
    );
        logic signed [plpe_pkg::POS_W:0] s;
        s = (plpe_pkg::POS_W+1)'(a) + (plpe_pkg::POS_W+1)'(d);
        if (s[plpe_pkg::POS_W] != s[plpe_pkg::POS_W-1]) begin
            return s[plpe_pkg::POS_W] ? POS_MIN : POS_MAX;
        end
        return s[plpe_pkg::POS_W-1:0];
    endfunction

    plpe_pkg::t_state r_state;
    plpe_pkg::t_state n_state;

    logic [plpe_pkg::TS_W-1:0]          r_time_step;
    logic signed [plpe_pkg::POS_W-1:0]  r_pos_x;
    logic signed [plpe_pkg::POS_W-1:0]  r_pos_y;
    logic [plpe_pkg::HDG_W-1:0]         r_heading;
    logic [plpe_pkg::CNT_W-1:0]         r_cnt;
    logic                               r_out_valid;
    plpe_pkg::t_out_word                r_out;

    logic [plpe_pkg::VEL_W-1:0]         r_vx_sh;
    logic [plpe_pkg::VEL_W-1:0]         r_vy_sh;
    logic signed [plpe_pkg::RATE_W-1:0] r_rate;
    logic [plpe_pkg::TS_W-1:0]          r_ts_sh;
    logic [plpe_pkg::TAB_W-1:0]         r_rom_q;
    logic                               r_rom_neg;
    logic signed [plpe_pkg::TRIG_W-1:0] r_sin;
    logic signed [plpe_pkg::TRIG_W-1:0] r_cos;
    logic signed [plpe_pkg::WIDE_W-1:0] r_a;
    logic signed [plpe_pkg::WIDE_W-1:0] r_b;
    logic signed [plpe_pkg::DX_W-1:0]   r_dx;
    logic signed [plpe_pkg::DX_W-1:0]   r_dy;
    logic [plpe_pkg::HDG_W-1:0]         r_dh;

    logic [plpe_pkg::TAB_W-1:0]         w_qsine [QUARTER_LEN+1];
    logic [ANGLE_BITS-1:0]              w_idx;
    logic [ANGLE_BITS-1:0]              w_sel_idx;
    logic [ROM_AW-1:0]                  w_rom_addr;
    logic signed [plpe_pkg::TRIG_W-1:0] w_trig_mag;
    logic signed [plpe_pkg::TRIG_W-1:0] w_trig;
    logic signed [plpe_pkg::TRIG_W-1:0] w_cx;
    logic signed [plpe_pkg::TRIG_W-1:0] w_sy;
    logic signed [plpe_pkg::TRIG_W-1:0] w_sx;
    logic signed [plpe_pkg::TRIG_W-1:0] w_cy;
    logic signed [plpe_pkg::TRIG_W+1:0] w_va;
    logic signed [plpe_pkg::TRIG_W+1:0] w_vb;
    logic signed [plpe_pkg::WIDE_W-1:0] w_va32;
    logic signed [plpe_pkg::WIDE_W-1:0] w_vb32;
    logic                               w_last;
    logic                               w_slot_free;
    logic                               w_cfg_wr;
    logic                               w_reg_idx;

    plpe_pkg::t_lane_ctl                w_ctl_rot;
    plpe_pkg::t_lane_ctl                w_ctl_hdg;
    logic signed [plpe_pkg::WIDE_W-1:0] w_add0;
    logic signed [plpe_pkg::WIDE_W-1:0] w_add1;
    logic signed [plpe_pkg::RATE_W-1:0] w_add2;
    logic signed [plpe_pkg::WIDE_W+plpe_pkg::SER_W-1:0] w_prod0;
    logic signed [plpe_pkg::WIDE_W+plpe_pkg::SER_W-1:0] w_prod1;
    logic signed [plpe_pkg::RATE_W+plpe_pkg::SER_W-1:0] w_prod2;
    logic signed [plpe_pkg::POS_W-1:0]  w_px_r;
    logic signed [plpe_pkg::POS_W-1:0]  w_py_r;
    logic signed [plpe_pkg::POS_W-1:0]  w_new_x;
    logic signed [plpe_pkg::POS_W-1:0]  w_new_y;
    logic [plpe_pkg::HDG_W-1:0]         w_new_h;

    // quarter-wave sine table
    for (genvar k = 0; k <= QUARTER_LEN; k++) begin : g_tab
        assign w_qsine[k] = plpe_pkg::quarter_sine(16'(k), 5'(ANGLE_BITS));
    end

    // table address: fold the angle into the first quadrant
    always_comb begin
        w_idx      = r_heading[plpe_pkg::HDG_W-1 -: ANGLE_BITS];
        w_sel_idx  = (r_state == plpe_pkg::ST_RD_COS) ? w_idx + QUARTER_IDX : w_idx;
        w_rom_addr = w_sel_idx[ANGLE_BITS-2]
                   ? QUARTER_ADDR - {1'b0, w_sel_idx[ANGLE_BITS-3:0]}
                   : {1'b0, w_sel_idx[ANGLE_BITS-3:0]};
        w_trig_mag = {1'b0, r_rom_q};
        w_trig     = r_rom_neg ? -w_trig_mag : w_trig_mag;
    end

    always_ff @(posedge i_clk) begin
        r_rom_q   <= w_qsine[w_rom_addr];
        r_rom_neg <= w_sel_idx[ANGLE_BITS-1];
    end

    // serial lane addends
    always_comb begin
        w_last = (r_cnt == CNT_LAST);
        w_cx   = r_vx_sh[0] ? r_cos : '0;
        w_sy   = r_vy_sh[0] ? r_sin : '0;
        w_sx   = r_vx_sh[0] ? r_sin : '0;
        w_cy   = r_vy_sh[0] ? r_cos : '0;
        w_va   = (plpe_pkg::TRIG_W+2)'(w_cx) - (plpe_pkg::TRIG_W+2)'(w_sy);
        w_vb   = (plpe_pkg::TRIG_W+2)'(w_sx) + (plpe_pkg::TRIG_W+2)'(w_cy);
        w_va32 = plpe_pkg::WIDE_W'(w_va);
        w_vb32 = plpe_pkg::WIDE_W'(w_vb);
        if (r_state == plpe_pkg::ST_VEL) begin
            // sign bit of the velocity carries negative weight
            w_add0 = w_last ? -w_va32 : w_va32;
            w_add1 = w_last ? -w_vb32 : w_vb32;
        end else begin
            w_add0 = r_ts_sh[0] ? r_a : '0;
            w_add1 = r_ts_sh[0] ? r_b : '0;
        end
        w_add2 = r_ts_sh[0] ? r_rate : '0;

        w_ctl_rot.clr = (r_state == plpe_pkg::ST_LD_COS) || (r_state == plpe_pkg::ST_MID);
        w_ctl_rot.en  = (r_state == plpe_pkg::ST_VEL) || (r_state == plpe_pkg::ST_STEP);
        w_ctl_hdg.clr = (r_state == plpe_pkg::ST_MID);
        w_ctl_hdg.en  = (r_state == plpe_pkg::ST_STEP);
    end

    plpe_lane #(.DW(plpe_pkg::WIDE_W)) u_lane_x (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl_rot),
        .i_addend (w_add0),
        .o_prod   (w_prod0)
    );

    plpe_lane #(.DW(plpe_pkg::WIDE_W)) u_lane_y (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl_rot),
        .i_addend (w_add1),
        .o_prod   (w_prod1)
    );

    plpe_lane #(.DW(plpe_pkg::RATE_W)) u_lane_h (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl_hdg),
        .i_addend (w_add2),
        .o_prod   (w_prod2)
    );

    // round half away from zero, then saturating update
    always_comb begin
        w_px_r  = w_prod0 + (w_prod0[plpe_pkg::POS_W-1] ? RND_NEG : RND_POS);
        w_py_r  = w_prod1 + (w_prod1[plpe_pkg::POS_W-1] ? RND_NEG : RND_POS);
        w_new_x = sat_add(r_pos_x, r_dx);
        w_new_y = sat_add(r_pos_y, r_dy);
        w_new_h = r_heading + r_dh;
    end

    always_comb begin
        w_slot_free = !r_out_valid || i_out_ready;
        n_state     = r_state;
        case (r_state)
            plpe_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = plpe_pkg::ST_RD_SIN;
                end
            end
            plpe_pkg::ST_RD_SIN: n_state = plpe_pkg::ST_RD_COS;
            plpe_pkg::ST_RD_COS: n_state = plpe_pkg::ST_LD_COS;
            plpe_pkg::ST_LD_COS: n_state = plpe_pkg::ST_VEL;
            plpe_pkg::ST_VEL: begin
                if (w_last) begin
                    n_state = plpe_pkg::ST_MID;
                end
            end
            plpe_pkg::ST_MID: n_state = plpe_pkg::ST_STEP;
            plpe_pkg::ST_STEP: begin
                if (w_last) begin
                    n_state = plpe_pkg::ST_ROUND;
                end
            end
            plpe_pkg::ST_ROUND: n_state = plpe_pkg::ST_UPDATE;
            plpe_pkg::ST_UPDATE: begin
                if (w_slot_free) begin
                    n_state = plpe_pkg::ST_IDLE;
                end
            end
            default: n_state = plpe_pkg::ST_IDLE;
        endcase
    end

    // configuration port
    always_comb begin
        w_reg_idx = paddr[plpe_pkg::ADDR_W-1];
        w_cfg_wr  = psel && penable && pwrite && (w_reg_idx == plpe_pkg::REG_TIME_STEP);
        prdata    = (w_reg_idx == plpe_pkg::REG_TIME_STEP)
                  ? {{(plpe_pkg::DATA_W-plpe_pkg::TS_W){1'b0}}, r_time_step} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plpe_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_time_step <= plpe_pkg::TIME_STEP_RESET;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == plpe_pkg::ST_LD_COS || r_state == plpe_pkg::ST_MID) begin
                r_cnt <= '0;
            end else if (r_state == plpe_pkg::ST_VEL || r_state == plpe_pkg::ST_STEP) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_cfg_wr) begin
                r_time_step <= pwdata[plpe_pkg::TS_W-1:0];
            end
            if (r_state == plpe_pkg::ST_UPDATE && w_slot_free) begin
                r_pos_x     <= w_new_x;
                r_pos_y     <= w_new_y;
                r_heading   <= w_new_h;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            plpe_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    r_vx_sh <= i_in_word.vel_x;
                    r_vy_sh <= i_in_word.vel_y;
                    r_rate  <= i_in_word.turn_rate;
                end
            end
            plpe_pkg::ST_RD_COS: r_sin <= w_trig;
            plpe_pkg::ST_LD_COS: r_cos <= w_trig;
            plpe_pkg::ST_VEL: begin
                r_vx_sh <= r_vx_sh >> 1;
                r_vy_sh <= r_vy_sh >> 1;
            end
            plpe_pkg::ST_MID: begin
                r_a     <= w_prod0[plpe_pkg::WIDE_W-1:0];
                r_b     <= w_prod1[plpe_pkg::WIDE_W-1:0];
                r_ts_sh <= r_time_step;
            end
            plpe_pkg::ST_STEP: r_ts_sh <= r_ts_sh >> 1;
            plpe_pkg::ST_ROUND: begin
                r_dx <= w_px_r[plpe_pkg::POS_W-1:15];
                r_dy <= w_py_r[plpe_pkg::POS_W-1:15];
                r_dh <= w_prod2[plpe_pkg::HDG_W-1:0];
            end
            plpe_pkg::ST_UPDATE: begin
                if (w_slot_free) begin
                    r_out.pos_x   <= w_new_x;
                    r_out.pos_y   <= w_new_y;
                    r_out.heading <= w_new_h;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready  = (r_state == plpe_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign pready      = 1'b1;

endmodule

// ===== hw/rtl/plpe_chk.sv =====
module plpe_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input plpe_pkg::t_out_word  o_out_word
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output not empty or input not ready after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken while one is in work");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result word appeared right after an accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word dropped or changed");

endmodule

bind planar_pose_euler_integrator plpe_chk u_plpe_chk (.*);

// ===== sim/tb_planar_pose_euler_integrator.sv =====
module tb_planar_pose_euler_integrator;

    localparam int CLK_PERIOD     = 12;
    localparam int TB_ANGLE_BITS  = 12;
    localparam int TABLE_QUARTER  = 1 << (TB_ANGLE_BITS - 2);
    localparam int SETTLE_CYCLES  = 45;
    localparam int HOLD_CYCLES    = 300;
    localparam int DIRECTED_ROWS  = 20;
    localparam longint POS_HI     = (longint'(1) <<< 47) - 1;
    localparam longint POS_LO     = -(longint'(1) <<< 47);
    localparam real PI            = 3.14159265358979323846;

    localparam logic [plpe_pkg::ADDR_W-1:0] TIME_STEP_ADDR =
        plpe_pkg::ADDR_W'(4 * plpe_pkg::REG_TIME_STEP);
    localparam logic [plpe_pkg::ADDR_W-1:0] SPARE_ADDR     = plpe_pkg::ADDR_W'(4);

    typedef struct packed {
        logic                check;
        plpe_pkg::t_in_word  word;
        plpe_pkg::t_out_word pose;
    } t_row;

    // velocity words; pose is typed in only where it is obvious
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        {1'b1, 16'sd0, 16'sd0, 24'sd0, 48'sd0, 48'sd0, 32'd0},
        {1'b1, 16'sd0, 16'sd0, 24'sd1000, 48'sd0, 48'sd0, 32'd655000},
        {1'b1, 16'sd1, 16'sd0, 24'sd0, 48'sd655, 48'sd0, 32'd655000},
        {1'b1, 16'sh8000, 16'sd0, 24'sd0, -48'sd21461730, 48'sd0, 32'd655000},
        {1'b0, 16'sd0, 16'sh7FFF, 24'sd0, 128'd0},
        {1'b0, 16'sd0, 16'sh8000, 24'sd0, 128'd0},
        {1'b0, 16'sh7FFF, 16'sh7FFF, 24'sh7FFFFF, 128'd0},
        {1'b0, 16'sh8000, 16'sh8000, 24'sh800000, 128'd0},
        {1'b0, 16'sh7FFF, 16'sh8000, 24'sd1639000, 128'd0},
        {1'b0, 16'sh8000, 16'sh7FFF, 24'sd1639000, 128'd0},
        {1'b0, 16'sh5555, 16'shAAAA, 24'sd1639000, 128'd0},
        {1'b0, 16'shAAAA, 16'sh5555, 24'sd1639000, 128'd0},
        {1'b0, 16'sd1000, -16'sd1000, -24'sd1639000, 128'd0},
        {1'b0, -16'sd1, -16'sd1, -24'sd1, 128'd0},
        {1'b0, 16'sd1, 16'sd1, 24'sd1, 128'd0},
        {1'b0, 16'sd0, 16'sd0, 24'sh555555, 128'd0},
        {1'b0, 16'sd0, 16'sd0, 24'shAAAAAA, 128'd0},
        {1'b0, 16'sd12345, -16'sd12345, -24'sd3278000, 128'd0},
        {1'b0, 16'sh7FFF, 16'sd0, 24'sd0, 128'd0},
        {1'b0, 16'sd0, 16'sh7FFF, 24'sd0, 128'd0}
    };

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    plpe_pkg::t_in_word            i_in_word   = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    plpe_pkg::t_out_word           o_out_word;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [plpe_pkg::ADDR_W-1:0]   paddr       = '0;
    logic [plpe_pkg::DATA_W-1:0]   pwdata      = '0;
    logic [plpe_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    int          quarter_wave [0:TABLE_QUARTER];
    logic [15:0] step_q16 = plpe_pkg::TIME_STEP_RESET;
    longint      pose_x = 0;
    longint      pose_y = 0;
    logic [31:0] pose_heading = '0;

    plpe_pkg::t_out_word expected_poses [$];
    int          mismatch_count = 0;
    int          burst_left = 0;
    bit          tx_free = 1'b0;
    bit          rx_free = 1'b0;
    bit          hold_request = 1'b0;

    planar_pose_euler_integrator #(
        .ANGLE_BITS (TB_ANGLE_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    function automatic int sine_at(input int unsigned idx);
        int unsigned quad;
        int unsigned j;
        int v;
        idx  = idx & ((1 << TB_ANGLE_BITS) - 1);
        quad = idx >> (TB_ANGLE_BITS - 2);
        j    = idx & (TABLE_QUARTER - 1);
        v    = quad[0] ? quarter_wave[TABLE_QUARTER - j] : quarter_wave[j];
        return quad[1] ? -v : v;
    endfunction

    function automatic longint round_q15(input longint p);
        if (p >= 0) begin
            return (p + 16384) >>> 15;
        end
        return -((16384 - p) >>> 15);
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > POS_HI) begin
            return POS_HI;
        end else if (v < POS_LO) begin
            return POS_LO;
        end
        return v;
    endfunction

    function automatic plpe_pkg::t_out_word advance_pose(input plpe_pkg::t_in_word w);
        longint vx;
        longint vy;
        longint rate;
        longint ts;
        longint sn;
        longint cs;
        int unsigned idx;
        plpe_pkg::t_out_word r;
        vx   = w.vel_x;
        vy   = w.vel_y;
        rate = w.turn_rate;
        ts   = step_q16;
        idx  = pose_heading >> (plpe_pkg::HDG_W - TB_ANGLE_BITS);
        sn   = sine_at(idx);
        cs   = sine_at(idx + TABLE_QUARTER);
        pose_x       = clamp_pos(pose_x + round_q15((cs * vx - sn * vy) * ts));
        pose_y       = clamp_pos(pose_y + round_q15((sn * vx + cs * vy) * ts));
        pose_heading = pose_heading + 32'(rate * ts);
        r.pos_x   = 48'(pose_x);
        r.pos_y   = 48'(pose_y);
        r.heading = pose_heading;
        return r;
    endfunction

    function automatic logic signed [15:0] pick_speed();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return -16'sd1;
            3:       return 16'sd0;
            4, 5:    return 16'($urandom_range(0, 200)) - 16'd100;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic plpe_pkg::t_in_word random_velocity();
        plpe_pkg::t_in_word w;
        w.vel_x = pick_speed();
        w.vel_y = pick_speed();
        case ($urandom_range(0, 7))
            0:       w.turn_rate = 24'sh800000;
            1:       w.turn_rate = 24'sh7FFFFF;
            2:       w.turn_rate = 24'($urandom_range(0, 2000)) - 24'd1000;
            default: w.turn_rate = 24'($urandom);
        endcase
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch: %s", what);
        end
    endtask

    task automatic send_velocity(input plpe_pkg::t_in_word w, input logic typed,
                                 input plpe_pkg::t_out_word pose);
        plpe_pkg::t_out_word p;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        p = advance_pose(w);
        expected_poses.push_back(typed ? pose : p);
    endtask

    task automatic pace_sender();
        int gap;
        if (!tx_free) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 60);
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 10);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic idle_until_empty(input int extra);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [plpe_pkg::ADDR_W-1:0] addr,
                                  input logic [plpe_pkg::DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((addr >> 2) == plpe_pkg::REG_TIME_STEP) begin
            step_q16 = data[plpe_pkg::TS_W-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_random(input int count, input int hold_at, input int pause_at);
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) begin
                hold_request = 1'b1;
            end
            if (n == pause_at) begin
                idle_until_empty(0);
            end
            pace_sender();
            send_velocity(random_velocity(), 1'b0, '0);
        end
    endtask

    // receiver stall pattern, with one long hold-off on request
    initial begin : rx_pattern
        bit level;
        int left;
        level = 1'b0;
        left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
                left = 0;
            end
            if (rx_free) begin
                i_out_ready <= 1'b1;
            end else if (left == 0) begin
                level = !level;
                if (level) begin
                    left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(1, 15);
                end else begin
                    left = $urandom_range(1, 10);
                end
                i_out_ready <= level;
            end else begin
                left--;
            end
        end
    end

    always @(posedge i_clk) begin : pose_check
        plpe_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_poses.size() == 0) begin
                report_mismatch($sformatf("unexpected pose word %0d %0d %0h",
                    o_out_word.pos_x, o_out_word.pos_y, o_out_word.heading));
            end else begin
                want = expected_poses.pop_front();
                if (o_out_word.pos_x !== want.pos_x) begin
                    report_mismatch($sformatf("pos_x expected %0d, got %0d",
                        want.pos_x, o_out_word.pos_x));
                end
                if (o_out_word.pos_y !== want.pos_y) begin
                    report_mismatch($sformatf("pos_y expected %0d, got %0d",
                        want.pos_y, o_out_word.pos_y));
                end
                if (o_out_word.heading !== want.heading) begin
                    report_mismatch($sformatf("heading expected %0h, got %0h",
                        want.heading, o_out_word.heading));
                end
            end
        end
    end

    initial begin : watchdog
        #(CLK_PERIOD * 6000000);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        real r;
        logic [31:0] turn_needed;
        plpe_pkg::t_in_word w;
        for (int k = 0; k <= TABLE_QUARTER; k++) begin
            r = 32767.0 * $sin(2.0 * PI * real'(k) / real'(1 << TB_ANGLE_BITS));
            quarter_wave[k] = int'($floor(r + 0.5));
            if (quarter_wave[k] > 32767) begin
                quarter_wave[k] = 32767;
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            pace_sender();
            send_velocity(DIRECTED[i].word, DIRECTED[i].check, DIRECTED[i].pose);
        end

        // spare address is ignored, upper data bits dropped
        idle_until_empty(SETTLE_CYCLES);
        write_register(SPARE_ADDR, 32'h0000_1234);
        write_register(TIME_STEP_ADDR, 32'hFFFF_0001);
        run_random(120, -1, -1);

        idle_until_empty(SETTLE_CYCLES);
        write_register(TIME_STEP_ADDR, 32'd0);
        run_random(60, -1, -1);

        idle_until_empty(SETTLE_CYCLES);
        write_register(TIME_STEP_ADDR, 32'h0000_FFFF);
        run_random(150, 30, -1);

        idle_until_empty(SETTLE_CYCLES);
        write_register(TIME_STEP_ADDR, {16'hA5A5, 16'($urandom_range(1, 65535))});
        run_random(150, -1, 70);

        idle_until_empty(SETTLE_CYCLES);
        write_register(TIME_STEP_ADDR, 32'(plpe_pkg::TIME_STEP_RESET));
        run_random(150, -1, -1);

        idle_until_empty(SETTLE_CYCLES);
        write_register(TIME_STEP_ADDR, 32'd32768);
        run_random(170, -1, 100);

        // turn to 45 degrees, then run at full speed both ways
        idle_until_empty(SETTLE_CYCLES);
        write_register(TIME_STEP_ADDR, 32'd16384);
        turn_needed = (32'h2008_0000 - pose_heading) >> 14;
        w.vel_x = 16'sd0;
        w.vel_y = 16'sd0;
        w.turn_rate = turn_needed[23:0];
        send_velocity(w, 1'b0, '0);
        idle_until_empty(SETTLE_CYCLES);
        write_register(TIME_STEP_ADDR, 32'h0000_FFFF);
        tx_free = 1'b1;
        rx_free = 1'b1;
        w.turn_rate = 24'sd0;
        w.vel_x = 16'sh7FFF;
        w.vel_y = 16'sh8000;
        repeat (8) send_velocity(w, 1'b0, '0);
        w.vel_x = 16'sh8000;
        w.vel_y = 16'sh7FFF;
        repeat (4) send_velocity(w, 1'b0, '0);

        idle_until_empty(SETTLE_CYCLES);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== planar_pose_euler_integrator.f =====
hw/rtl/plpe_pkg.sv
hw/rtl/plpe_lane.sv
hw/rtl/planar_pose_euler_integrator.sv
hw/rtl/plpe_chk.sv
sim/tb_planar_pose_euler_integrator.sv
